FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define JSUD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define JSUD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/jsud_pkg.sv
// Shared types and codes of the JSON string unescape decoder.
`default_nettype none

package jsud_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EXPECTED  = 3'd1;
  localparam logic [2:0] ERR_UNTERM    = 3'd2;
  localparam logic [2:0] ERR_TRUNC_ESC = 3'd3;
  localparam logic [2:0] ERR_TRUNC_UNI = 3'd4;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd5;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd6;

  // All results caused by one input word; cnt is 1..3.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] err;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } pkt_t;

endpackage

`default_nettype wire

FILE: rtl/json_string_unescape_decoder_top.sv
// Top level of the JSON string unescape decoder.
//  channel | dir | handshake             | fields
//  in      | in  | in_valid_i/in_ready_o | data_byte_i, final_byte_i
//  out     | out | out_valid_o/out_ready_i | result_kind_o, decoded_byte_o,
//          |     |                       | error_code_o, run_last_o
// One input word per cycle while the packet queue has room; parse state is registered per accepted word.
// A \u escape yields up to three result words, played out one per cycle by
// the back end while out_ready_i is high.
// Async active-low reset returns to awaiting an opening quote; queue empties.
// Input stalls only when the packet queue is full.
`default_nettype none
`include "assert_macros.svh"

module json_string_unescape_decoder_top #(
  parameter int unsigned QueueDepth = jsud_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      decoded_byte_o,
  output logic [2:0]      error_code_o,
  output logic            run_last_o
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  jsud_pkg::pkt_t push_pkt, pop_pkt;

  jsud_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_pkt_o   (push_pkt)
  );

  jsud_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_pkt_i   (push_pkt),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_pkt_o    (pop_pkt)
  );

  jsud_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_pkt_i      (pop_pkt),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .decoded_byte_o (decoded_byte_o),
    .error_code_o   (error_code_o),
    .run_last_o     (run_last_o)
  );

  `JSUD_ASSERT(a_err_is_last, out_valid_o && result_kind_o == jsud_pkg::KIND_ERR |-> run_last_o, "error word not last")
  `JSUD_ASSERT(a_end_is_last, out_valid_o && result_kind_o == jsud_pkg::KIND_END |-> run_last_o, "end word not last")
  `JSUD_ASSERT(a_err_code, out_valid_o |-> ((result_kind_o == jsud_pkg::KIND_ERR) == (error_code_o != jsud_pkg::ERR_NONE)), "error code mismatch")
  `JSUD_NEVER(a_kind_range, out_valid_o && result_kind_o != jsud_pkg::KIND_BYTE && result_kind_o != jsud_pkg::KIND_END && result_kind_o != jsud_pkg::KIND_ERR, "bad result kind")

endmodule

`default_nettype wire

FILE: rtl/jsud_front.sv
// Front end: parses each input word and builds a result packet for words that yield one.
`default_nettype none

module jsud_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          final_byte_i,
  input  wire logic          push_ready_i,
  output logic               push_valid_o,
  output jsud_pkg::pkt_t     push_pkt_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_STR  = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_UNI  = 2'd3;

  logic [1:0]     phase_q, phase_d;
  logic [1:0]     hex_seen_q, hex_seen_d;
  logic [15:0]    code_q, code_d;
  logic           accept;
  logic           has_res;
  logic           hex_ok;
  logic [3:0]     hex_val;
  logic [15:0]    code_next;
  jsud_pkg::pkt_t pkt;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      hex_val = 4'(data_byte_i - 8'h30);
    end else if (data_byte_i >= 8'h61 && data_byte_i <= 8'h66) begin
      hex_val = 4'(data_byte_i - 8'h57);
    end else if (data_byte_i >= 8'h41 && data_byte_i <= 8'h46) begin
      hex_val = 4'(data_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign code_next = {code_q[11:0], hex_val};

  always_comb begin
    logic       fail;
    logic [2:0] fcode;
    fail       = 1'b0;
    fcode      = jsud_pkg::ERR_NONE;
    phase_d    = phase_q;
    hex_seen_d = hex_seen_q;
    code_d     = code_q;
    has_res    = 1'b0;
    pkt        = '0;
    pkt.kind   = jsud_pkg::KIND_BYTE;
    pkt.cnt    = 2'd1;
    unique case (phase_q)
      PH_IDLE: begin
        if (data_byte_i == 8'h22) begin
          phase_d = PH_STR;
          if (final_byte_i) begin
            fail  = 1'b1;
            fcode = jsud_pkg::ERR_UNTERM;
          end
        end else if (!(data_byte_i == 8'h20 ||
                       (data_byte_i >= 8'h09 && data_byte_i <= 8'h0D))) begin
          fail  = 1'b1;
          fcode = jsud_pkg::ERR_EXPECTED;
        end
      end
      PH_STR: begin
        if (data_byte_i == 8'h22) begin
          has_res  = 1'b1;
          pkt.kind = jsud_pkg::KIND_END;
          phase_d  = PH_IDLE;
        end else if (data_byte_i == 8'h5C) begin
          phase_d = PH_ESC;
          if (final_byte_i) begin
            fail  = 1'b1;
            fcode = jsud_pkg::ERR_TRUNC_ESC;
          end
        end else begin
          has_res = 1'b1;
          pkt.b0  = data_byte_i;
          if (final_byte_i) begin
            fail  = 1'b1;
            fcode = jsud_pkg::ERR_UNTERM;
          end
        end
      end
      PH_ESC: begin
        phase_d = PH_STR;
        has_res = 1'b1;
        case (data_byte_i)
          8'h22, 8'h5C, 8'h2F: pkt.b0 = data_byte_i;
          8'h62: pkt.b0 = 8'h08;
          8'h66: pkt.b0 = 8'h0C;
          8'h6E: pkt.b0 = 8'h0A;
          8'h72: pkt.b0 = 8'h0D;
          8'h74: pkt.b0 = 8'h09;
          8'h75: begin
            has_res    = 1'b0;
            phase_d    = PH_UNI;
            hex_seen_d = 2'd0;
            code_d     = 16'd0;
          end
          default: begin
            fail  = 1'b1;
            fcode = jsud_pkg::ERR_BAD_ESC;
          end
        endcase
        if (final_byte_i && !fail) begin
          fail  = 1'b1;
          fcode = (data_byte_i == 8'h75) ? jsud_pkg::ERR_TRUNC_UNI : jsud_pkg::ERR_UNTERM;
        end
      end
      PH_UNI: begin
        if (!hex_ok) begin
          fail  = 1'b1;
          fcode = jsud_pkg::ERR_BAD_HEX;
        end else if (hex_seen_q == 2'd3) begin
          has_res    = 1'b1;
          hex_seen_d = 2'd0;
          phase_d    = PH_STR;
          code_d     = 16'd0;
          if (code_next <= 16'h007F) begin
            pkt.cnt = 2'd1;
            pkt.b0  = code_next[7:0];
          end else if (code_next <= 16'h07FF) begin
            pkt.cnt = 2'd2;
            pkt.b0  = 8'hC0 | {3'b000, code_next[10:6]};
            pkt.b1  = 8'h80 | {2'b00, code_next[5:0]};
          end else begin
            pkt.cnt = 2'd3;
            pkt.b0  = 8'hE0 | {4'h0, code_next[15:12]};
            pkt.b1  = 8'h80 | {2'b00, code_next[11:6]};
            pkt.b2  = 8'h80 | {2'b00, code_next[5:0]};
          end
          if (final_byte_i) begin
            fail  = 1'b1;
            fcode = jsud_pkg::ERR_UNTERM;
          end
        end else begin
          code_d     = code_next;
          hex_seen_d = hex_seen_q + 2'd1;
          if (final_byte_i) begin
            fail  = 1'b1;
            fcode = jsud_pkg::ERR_TRUNC_UNI;
          end
        end
      end
      default: ;
    endcase
    if (fail) begin
      has_res    = 1'b1;
      pkt        = '0;
      pkt.kind   = jsud_pkg::KIND_ERR;
      pkt.err    = fcode;
      pkt.cnt    = 2'd1;
      phase_d    = PH_IDLE;
      hex_seen_d = 2'd0;
      code_d     = 16'd0;
    end
  end

  assign push_valid_o = accept & has_res;
  assign push_pkt_o   = pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      hex_seen_q <= 2'd0;
      code_q     <= 16'd0;
    end else if (accept) begin
      phase_q    <= phase_d;
      hex_seen_q <= hex_seen_d;
      code_q     <= code_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jsud_fifo.sv
// Small packet queue between front and back end.
`default_nettype none

module jsud_fifo #(
  parameter int unsigned Depth = jsud_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire jsud_pkg::pkt_t push_pkt_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output jsud_pkg::pkt_t      pop_pkt_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  jsud_pkg::pkt_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_pkt_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jsud_back.sv
// Back end: plays out each packet as one to three result words.
`default_nettype none

module jsud_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  input  wire jsud_pkg::pkt_t pop_pkt_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          result_kind_o,
  output logic [7:0]          decoded_byte_o,
  output logic [2:0]          error_code_o,
  output logic                run_last_o
);

  jsud_pkg::pkt_t cur_q;
  logic           vld_q;
  logic [1:0]     idx_q;
  logic           last;
  logic           done;
  logic [7:0]     sel_byte;

  assign last        = (idx_q == cur_q.cnt - 2'd1);
  assign done        = vld_q & out_ready_i;
  assign pop_ready_o = !vld_q || (out_ready_i && last);

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = cur_q.b0;
      2'd1:    sel_byte = cur_q.b1;
      default: sel_byte = cur_q.b2;
    endcase
  end

  assign out_valid_o    = vld_q;
  assign result_kind_o  = cur_q.kind;
  assign decoded_byte_o = (cur_q.kind == jsud_pkg::KIND_BYTE) ? sel_byte : 8'd0;
  assign error_code_o   = (cur_q.kind == jsud_pkg::KIND_ERR) ? cur_q.err : jsud_pkg::ERR_NONE;
  assign run_last_o     = last;

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      cur_q <= pop_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (pop_ready_o) begin
      vld_q <= pop_valid_i;
      idx_q <= 2'd0;
    end else if (done) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire
